/* src/linear_array_queue_with_search_unit_assert.svh */
// ---------------------------------------------------------------------------
// linear array queue assertion macros
// clocked assertion helpers shared by the queue rtl
// ---------------------------------------------------------------------------
`ifndef LINEAR_ARRAY_QUEUE_WITH_SEARCH_UNIT_ASSERT_SVH
`define LINEAR_ARRAY_QUEUE_WITH_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LQS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LQS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lqs_pkg.sv */
// ---------------------------------------------------------------------------
// lqs_pkg
// operation and status codes and fixed field widths of the array queue
// ---------------------------------------------------------------------------
package lqs_pkg;

  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;
  localparam int CAP_W   = 5;
  localparam int FIELD_W = 32;

  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [STAT_W-1:0]  stat_t;
  typedef logic [CAP_W-1:0]   cap_t;
  typedef logic [FIELD_W-1:0] field_t;

  localparam kind_t KIND_ENQ    = 2'd0;
  localparam kind_t KIND_DEQ    = 2'd1;
  localparam kind_t KIND_SEARCH = 2'd2;

  localparam stat_t STAT_OK       = 2'd0;
  localparam stat_t STAT_OVERFLOW = 2'd1;
  localparam stat_t STAT_EMPTY    = 2'd2;

  localparam cap_t CAP_RESET = 5'd16;

endpackage

/* src/linear_array_queue_with_search_unit.sv */
// ---------------------------------------------------------------------------
// linear_array_queue_with_search_unit
// non-wrapping array queue with enqueue, dequeue and key search
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | kind, push_value, search_key
//  out_    | output    | out_valid / out_ready | status, data_out, found,
//          |           |                       | occupancy, is_empty, is_full
//  cfg_    | input     | cfg_valid / cfg_ready | capacity (cfg_data)
//
//  enqueue, dequeue and unused kinds pass, after accept, through index
//  update with slot read, result capture and output load. a search of an
//  active queue instead scans n slots (n up to occupancy) through the single
//  read port, walked one slot a cycle, and then loads the output register.
//  one item is in work at a time; in_ready rises again when the result has
//  moved to the output register, so the next beat may enter while it waits.
//  a stalled output register holds the unit in its last state.
//  reset is synchronous and active low and empties the queue at once.
//  cfg_ready is always high.
// ---------------------------------------------------------------------------
`include "linear_array_queue_with_search_unit_assert.svh"

module linear_array_queue_with_search_unit
  import lqs_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  kind_t              in_kind,
  input  logic signed [31:0] in_push_value,
  input  logic signed [31:0] in_search_key,
  output logic               out_valid,
  input  logic               out_ready,
  output stat_t              out_status,
  output logic signed [31:0] out_data_out,
  output logic               out_found,
  output logic [4:0]         out_occupancy,
  output logic               out_is_empty,
  output logic               out_is_full,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  cap_t               cfg_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW = ((IW > CAP_W) ? IW : CAP_W) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OP   = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]            state_r, state_nxt;
  cap_t                  cap_r;
  logic                  active_r, active_nxt;
  logic [IW-1:0]         head_r, head_nxt;
  logic [IW-1:0]         tail_r, tail_nxt;
  logic [CAP_W-1:0]      count_r, count_nxt;

  kind_t                 kind_r;
  logic [DATA_WIDTH-1:0] push_r;
  logic [DATA_WIDTH-1:0] key_r;
  logic                  hv_r, hv_nxt;
  logic                  first_r, first_nxt;
  logic [IW-1:0]         scan_r, scan_nxt;
  stat_t                 res_status_r, res_status_nxt;
  field_t                res_data_r, res_data_nxt;
  logic                  res_found_r, res_found_nxt;

  logic                  out_valid_r;
  stat_t                 out_status_r;
  field_t                out_data_r;
  logic                  out_found_r;
  logic [CAP_W-1:0]      out_occ_r;
  logic                  out_empty_r;
  logic                  out_full_r;

  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  logic [IW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;
  logic [63:0]           rd_ext;
  field_t                rd32;

  logic [XW-1:0]         cap_x;
  logic [XW-1:0]         cap_use;
  logic                  full_now;
  logic                  out_free;
  logic [63:0]           push_ext;
  logic [63:0]           key_ext;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_ready;

  assign push_ext = {{32{in_push_value[31]}}, in_push_value};
  assign key_ext  = {{32{in_search_key[31]}}, in_search_key};

  assign rd_ext = 64'(mem_rdata);
  assign rd32   = rd_ext[31:0];

  // capacity beyond the slot count is clipped to it
  assign cap_x    = XW'(cap_r);
  assign cap_use  = (cap_x > XW'(DEPTH)) ? XW'(DEPTH) : cap_x;
  assign full_now = active_r ? ((XW'(tail_r) + XW'(1)) >= cap_use)
                             : (cap_use == '0);

  lqs_slots #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (IW)
  ) u_slots (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (push_r),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    hv_nxt         = hv_r;
    first_nxt      = first_r;
    scan_nxt       = scan_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    res_found_nxt  = res_found_r;
    mem_we         = 1'b0;
    mem_waddr      = tail_r;
    mem_raddr      = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_OP;
        end
      end
      S_OP: begin
        res_status_nxt = STAT_OK;
        res_found_nxt  = 1'b0;
        state_nxt      = S_WAIT;
        hv_nxt         = active_r;
        case (kind_r)
          KIND_ENQ: begin
            if (full_now) begin
              res_status_nxt = STAT_OVERFLOW;
            end else begin
              if (!active_r) begin
                active_nxt = 1'b1;
                head_nxt   = '0;
                tail_nxt   = '0;
                mem_waddr  = '0;
                mem_raddr  = '0;
              end else begin
                tail_nxt  = tail_r + IW'(1);
                mem_waddr = tail_r + IW'(1);
              end
              mem_we    = 1'b1;
              hv_nxt    = 1'b1;
              count_nxt = count_r + CAP_W'(1);
            end
          end
          KIND_DEQ: begin
            if (!active_r) begin
              res_status_nxt = STAT_EMPTY;
            end else if (head_r == tail_r) begin
              active_nxt = 1'b0;
              head_nxt   = '0;
              tail_nxt   = '0;
              count_nxt  = '0;
            end else begin
              head_nxt  = head_r + IW'(1);
              count_nxt = count_r - CAP_W'(1);
            end
          end
          KIND_SEARCH: begin
            if (active_r) begin
              scan_nxt  = head_r;
              first_nxt = 1'b1;
              state_nxt = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_WAIT: begin
        res_data_nxt = hv_r ? rd32 : '1;
        state_nxt    = S_OUT;
      end
      S_SCAN: begin
        // read data belongs to the slot at scan_r
        first_nxt = 1'b0;
        if (first_r) begin
          res_data_nxt = rd32;
        end
        if (mem_rdata == key_r) begin
          res_found_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else if (scan_r == tail_r) begin
          state_nxt = S_OUT;
        end else begin
          scan_nxt  = scan_r + IW'(1);
          mem_raddr = scan_r + IW'(1);
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cap_r    <= CAP_RESET;
      active_r <= 1'b0;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      first_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      first_r  <= first_nxt;
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    hv_r         <= hv_nxt;
    scan_r       <= scan_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    res_found_r  <= res_found_nxt;
    if (in_valid && in_ready) begin
      kind_r <= in_kind;
      push_r <= push_ext[DATA_WIDTH-1:0];
      key_r  <= key_ext[DATA_WIDTH-1:0];
    end
  end

  // output register; occupancy and flags come from the settled state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_status_r <= res_status_r;
      out_data_r   <= res_data_r;
      out_found_r  <= res_found_r;
      out_occ_r    <= count_r;
      out_empty_r  <= !active_r;
      out_full_r   <= full_now;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_data_out  = out_data_r;
  assign out_found     = out_found_r;
  assign out_occupancy = out_occ_r;
  assign out_is_empty  = out_empty_r;
  assign out_is_full   = out_full_r;

  `LQS_ASSERT_IMP(a_idle_state, !active_r,
                  (count_r == '0) && (head_r == '0) && (tail_r == '0),
                  "inactive queue holds stale indices")
  `LQS_ASSERT_IMP(a_count_span, active_r,
                  (head_r <= tail_r) &&
                  (XW'(count_r) == XW'(tail_r) - XW'(head_r) + XW'(1)),
                  "occupancy disagrees with head and tail")
  `LQS_ASSERT_IMP(a_write_in_op, mem_we,
                  (state_r == S_OP) && (kind_r == KIND_ENQ) && !full_now,
                  "slot write outside an accepted enqueue")
  `LQS_ASSERT_NXT(a_out_load, (state_r == S_OUT) && out_free,
                  out_valid_r && (state_r == S_IDLE),
                  "result not moved to output register")

endmodule

/* src/lqs_slots.sv */
// ---------------------------------------------------------------------------
// lqs_slots
// slot storage: one write port, one registered read port, write forwarding
// ---------------------------------------------------------------------------
module lqs_slots #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 4
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [AW-1:0]         raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] mem_q_r;
  logic [DATA_WIDTH-1:0] byp_data_r;
  logic                  byp_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    mem_q_r    <= mem[raddr];
    // read of the entry being written returns the new value
    byp_r      <= we && (waddr == raddr);
    byp_data_r <= wdata;
  end

  assign rdata = byp_r ? byp_data_r : mem_q_r;

endmodule
